// ===== rtl/rgb555_tint_and_fade_unit_defines.svh =====
`ifndef RGB555_TINT_AND_FADE_UNIT_DEFINES_SVH
`define RGB555_TINT_AND_FADE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RTFU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RTFU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtfu_pkg.sv =====
package rtfu_pkg;

  localparam int unsigned ChW    = 5;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned QBits  = 5;
  localparam int unsigned RemW   = 13;
  localparam int unsigned NumCells = QBits;

  localparam logic [ChW-1:0] ChMax = 5'd31;
  localparam logic [7:0] LumaR = 8'd76;
  localparam logic [7:0] LumaG = 8'd151;
  localparam logic [7:0] LumaB = 8'd29;

  localparam logic [2:0] RegMode     = 3'd0;
  localparam logic [2:0] RegRedTone  = 3'd1;
  localparam logic [2:0] RegGrnTone  = 3'd2;
  localparam logic [2:0] RegBluTone  = 3'd3;
  localparam logic [2:0] RegTarget   = 3'd4;
  localparam logic [2:0] RegStep     = 3'd5;
  localparam logic [2:0] RegDuration = 3'd6;

  typedef enum logic [1:0] {
    MODE_GRAY = 2'd0,
    MODE_TONE = 2'd1,
    MODE_FADE = 2'd2,
    MODE_RAW  = 2'd3
  } mode_e_t;

  // one color channel on its way through the divider
  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [RemW-1:0] rem;
    logic [QBits-1:0] q;
  } lane_t;

  typedef struct packed {
    logic              last;
    mode_e_t           mode;
    logic [14:0]       color;
    logic [ChW-1:0]    gray;
    logic              bypass;
    lane_t [NumCh-1:0] lane;
  } stage_t;

endpackage

// ===== rtl/rtfu_prep.sv =====
module rtfu_prep import rtfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] color_in,
  input  logic        last_in,
  input  mode_e_t     mode,
  input  logic [14:0] target,
  input  logic [7:0]  step,
  input  logic [7:0]  duration,
  output logic        out_valid,
  output stage_t      out_stage
);

  logic   valid_r;
  stage_t stage_r;
  stage_t stage_nxt;
  logic [12:0] luma_sum;
  logic [ChW-1:0] c_k;
  logic [ChW-1:0] t_k;
  logic [ChW-1:0] absd;
  logic [RemW-1:0] mag;
  logic [RemW-1:0] lim;

  always_comb begin
    c_k = '0;
    t_k = '0;
    absd = '0;
    mag = '0;
    luma_sum = 13'(LumaR) * 13'(color_in[4:0]) + 13'(LumaG) * 13'(color_in[9:5])
             + 13'(LumaB) * 13'(color_in[14:10]);
    lim = {duration, 5'b0};
    stage_nxt.last   = last_in;
    stage_nxt.mode   = mode;
    stage_nxt.color  = color_in[14:0];
    stage_nxt.gray   = luma_sum[12:8];
    stage_nxt.bypass = (duration == 8'd0);
    for (int k = 0; k < NumCh; k++) begin
      c_k  = color_in[ChW*k +: ChW];
      t_k  = target[ChW*k +: ChW];
      absd = (t_k < c_k) ? (c_k - t_k) : (t_k - c_k);
      mag  = RemW'(absd) * RemW'(step);
      stage_nxt.lane[k].neg = (t_k < c_k);
      // quotient of 32 or more clamps the same as 31
      stage_nxt.lane[k].ovf = (mag >= lim);
      stage_nxt.lane[k].rem = mag;
      stage_nxt.lane[k].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// ===== rtl/rtfu_div_cell.sv =====
module rtfu_div_cell import rtfu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] divisor,
  input  logic       in_valid,
  input  stage_t     in_stage,
  output logic       out_valid,
  output stage_t     out_stage
);

  logic   valid_r;
  stage_t stage_r;
  stage_t stage_nxt;
  logic [RemW-1:0] lim;
  logic [RemW-1:0] rem_sub;
  logic            ge;

  // one restoring step per channel: compare against 16*d, then shift left
  always_comb begin
    stage_nxt = in_stage;
    lim = {1'b0, divisor, 4'b0};
    ge = 1'b0;
    rem_sub = '0;
    for (int k = 0; k < NumCh; k++) begin
      ge = (in_stage.lane[k].rem >= lim);
      rem_sub = ge ? (in_stage.lane[k].rem - lim) : in_stage.lane[k].rem;
      stage_nxt.lane[k].rem = {rem_sub[RemW-2:0], 1'b0};
      stage_nxt.lane[k].q   = {in_stage.lane[k].q[QBits-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// ===== rtl/rgb555_tint_and_fade_unit.sv =====
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata[15:0] color_in, tlast last_color
// out_    | out | out_tvalid/tready  | tdata[14:0] color_out, tdata[15] zero, tlast last_out
// cfg_    | in  | cfg_wen            | cfg_addr register index, cfg_wdata value
//
// one request per cycle when the output is taken; registers on the path:
// (prep stage, five divider cells, output register)
// the chain of divider cells, one quotient bit each, sets the latency
// rst_n is synchronous; it empties the pipeline and loads register defaults
// a stall at out_tready freezes the whole chain and drops in_tready
`include "rgb555_tint_and_fade_unit_defines.svh"

module rgb555_tint_and_fade_unit import rtfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] color_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] color_out, [15] zero fill
  output logic        out_tlast,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  mode_e_t      mode_r, mode_nxt;
  logic [10:0]  tone_r   [NumCh];
  logic [10:0]  tone_nxt [NumCh];
  logic [14:0]  target_r, target_nxt;
  logic [7:0]   step_r, step_nxt;
  logic [7:0]   dur_r, dur_nxt;

  logic        adv;
  logic        cell_v [NumCells+1];
  stage_t      cell_s [NumCells+1];

  logic        out_tvalid_r;
  logic [14:0] out_color_r, out_color_nxt;
  logic        out_last_r;

  stage_t      fin;
  logic [15:0] prod;
  logic [ChW-1:0] tone_ch [NumCh];
  logic [ChW-1:0] fade_ch [NumCh];
  logic [ChW-1:0] c_k;
  logic [ChW-1:0] qs;
  logic [ChW:0]   sum;

  // configuration registers
  always_comb begin
    mode_nxt   = mode_r;
    tone_nxt   = tone_r;
    target_nxt = target_r;
    step_nxt   = step_r;
    dur_nxt    = dur_r;
    if (cfg_wen) begin
      case (cfg_addr)
        RegMode:     mode_nxt    = mode_e_t'(cfg_wdata[1:0]);
        RegRedTone:  tone_nxt[0] = cfg_wdata[10:0];
        RegGrnTone:  tone_nxt[1] = cfg_wdata[10:0];
        RegBluTone:  tone_nxt[2] = cfg_wdata[10:0];
        RegTarget:   target_nxt  = cfg_wdata;
        RegStep:     step_nxt    = cfg_wdata[7:0];
        RegDuration: dur_nxt     = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_GRAY;
      tone_r   <= '{default: 11'd256};
      target_r <= '0;
      step_r   <= '0;
      dur_r    <= 8'd1;
    end else begin
      mode_r   <= mode_nxt;
      tone_r   <= tone_nxt;
      target_r <= target_nxt;
      step_r   <= step_nxt;
      dur_r    <= dur_nxt;
    end
  end

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  rtfu_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .color_in  (in_tdata),
    .last_in   (in_tlast),
    .mode      (mode_r),
    .target    (target_r),
    .step      (step_r),
    .duration  (dur_r),
    .out_valid (cell_v[0]),
    .out_stage (cell_s[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rtfu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .divisor   (dur_r),
      .in_valid  (cell_v[i]),
      .in_stage  (cell_s[i]),
      .out_valid (cell_v[i+1]),
      .out_stage (cell_s[i+1])
    );
  end

  assign fin = cell_s[NumCells];

  // final per-mode selection
  always_comb begin
    prod = '0;
    c_k  = '0;
    qs   = '0;
    sum  = '0;
    for (int k = 0; k < NumCh; k++) begin
      prod = 16'(tone_r[k]) * 16'(fin.gray);
      tone_ch[k] = (prod[15:8] > 8'(ChMax)) ? ChMax : prod[12:8];
      c_k = fin.color[ChW*k +: ChW];
      qs  = fin.lane[k].ovf ? ChMax : fin.lane[k].q;
      sum = {1'b0, c_k} + {1'b0, qs};
      if (fin.lane[k].neg) begin
        fade_ch[k] = (c_k > qs) ? (c_k - qs) : '0;
      end else begin
        fade_ch[k] = (sum > {1'b0, ChMax}) ? ChMax : sum[ChW-1:0];
      end
    end
    case (fin.mode)
      MODE_GRAY: out_color_nxt = {fin.gray, fin.gray, fin.gray};
      MODE_TONE: out_color_nxt = {tone_ch[2], tone_ch[1], tone_ch[0]};
      MODE_FADE: out_color_nxt = fin.bypass ? fin.color
                                            : {fade_ch[2], fade_ch[1], fade_ch[0]};
      default:   out_color_nxt = fin.color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= cell_v[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r <= out_color_nxt;
      out_last_r  <= fin.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_color_r};
  assign out_tlast  = out_last_r;

  `RTFU_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, cell_v[0], "accepted request did not enter prep stage")
  `RTFU_ASSERT_NEXT(a_chain_moves, clk, rst_n, adv && cell_v[0], cell_v[1], "request lost between prep and first cell")
  `RTFU_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv && cell_v[NumCells], cell_v[NumCells] && out_tvalid, "chain moved during output stall")
  `RTFU_ASSERT_NOW(a_gray_equal, clk, rst_n, out_tvalid && mode_r == MODE_GRAY, out_tdata[4:0] == out_tdata[9:5] && out_tdata[9:5] == out_tdata[14:10], "gray channels differ")

endmodule

// ===== sim/rgb555_tint_and_fade_unit_tb.sv =====
`timescale 1ns / 100ps

module rgb555_tint_and_fade_unit_tb import rtfu_pkg::*;;

  // index past the last register, writes to it must be ignored
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    logic        last;
    logic [14:0] color;
  } tinted_t;

  class tint_checker;
    mode_e_t     mode;
    logic [10:0] tone [3];
    logic [14:0] target;
    logic [7:0]  step;
    logic [7:0]  duration;
    tinted_t     expected_colors [$];
    int          errors;

    function new();
      mode     = MODE_GRAY;
      tone[0]  = 11'd256;
      tone[1]  = 11'd256;
      tone[2]  = 11'd256;
      target   = '0;
      step     = '0;
      duration = 8'd1;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [14:0] value);
      case (addr)
        RegMode:     mode = mode_e_t'(value[1:0]);
        RegRedTone:  tone[0] = value[10:0];
        RegGrnTone:  tone[1] = value[10:0];
        RegBluTone:  tone[2] = value[10:0];
        RegTarget:   target = value;
        RegStep:     step = value[7:0];
        RegDuration: duration = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [14:0] tint_color(logic [15:0] color_in);
      int unsigned gray;
      int unsigned prod;
      int unsigned quo;
      int          diff;
      int          moved;
      int          chan;
      int          goal;
      logic [4:0]  res [3];
      gray = (76 * int'(color_in[4:0]) + 151 * int'(color_in[9:5])
              + 29 * int'(color_in[14:10])) >> 8;
      for (int k = 0; k < 3; k++) begin
        chan = int'(color_in[5*k +: 5]);
        goal = int'(target[5*k +: 5]);
        case (mode)
          MODE_GRAY: res[k] = gray[4:0];
          MODE_TONE: begin
            prod = ((tone[k] * gray) & 32'hFFFF) >> 8;
            res[k] = (prod > 31) ? 5'd31 : prod[4:0];
          end
          MODE_FADE: begin
            if (duration == 0) begin
              res[k] = chan[4:0];
            end else begin
              diff = goal - chan;
              quo = ((diff < 0) ? -diff : diff) * step / duration;
              moved = (diff < 0) ? chan - int'(quo) : chan + int'(quo);
              if (moved < 0) moved = 0;
              if (moved > 31) moved = 31;
              res[k] = moved[4:0];
            end
          end
          default: res[k] = chan[4:0];
        endcase
      end
      return {res[2], res[1], res[0]};
    endfunction

    function void note_color(logic [15:0] color_in, logic last);
      tinted_t t;
      t.color = tint_color(color_in);
      t.last  = last;
      expected_colors.push_back(t);
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_color(logic [15:0] data, logic last);
      tinted_t t;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected color %h", data));
      end else begin
        t = expected_colors.pop_front();
        if (data[14:0] !== t.color)
          report_mismatch($sformatf("color %h, want %h", data[14:0], t.color));
        if (data[15] !== 1'b0)
          report_mismatch("bit 15 of color not zero");
        if (last !== t.last)
          report_mismatch($sformatf("last %b, want %b", last, t.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [14:0] cfg_wdata = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_id = 0;
  tint_checker chk;

  rgb555_tint_and_fade_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request of the main flow
  initial begin
    int unsigned seen_hold;
    int unsigned hold_left;
    seen_hold = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        chk.check_color(out_tdata, out_tlast);
      if (hold_id != seen_hold) begin
        seen_hold = hold_id;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_color(input logic [15:0] color, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    chk.note_color(color, last);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [14:0] value);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    chk.set_reg(addr, value);
  endtask

  task automatic program_regs(input mode_e_t mode, input logic [10:0] red,
                              input logic [10:0] grn, input logic [10:0] blu,
                              input logic [14:0] target, input logic [7:0] step,
                              input logic [7:0] dur, input bit junk);
    write_reg(RegMode, 15'(mode));
    write_reg(RegRedTone, 15'(red));
    write_reg(RegGrnTone, 15'(grn));
    write_reg(RegBluTone, 15'(blu));
    write_reg(RegTarget, target);
    write_reg(RegStep, 15'(step));
    write_reg(RegDuration, 15'(dur));
    if (junk)
      write_reg(RegUnused, 15'($urandom_range(0, 32767)));
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [10:0] pick_tone();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_color();
    logic [15:0] c;
    c = 16'($urandom_range(0, 65535));
    // channels pinned to the rails now and then
    if ($urandom_range(0, 7) == 0) begin
      for (int k = 0; k < 3; k++)
        c[5*k +: 5] = $urandom_range(0, 1) ? 5'd31 : 5'd0;
    end
    return c;
  endfunction

  initial begin
    mode_e_t     mode;
    logic [7:0]  dur;
    int unsigned sel;
    chk = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: grayscale
    send_color(16'h0000, 1'b0);
    send_color(16'hFFFF, 1'b1);
    send_color(16'h7FFF, 1'b0);
    send_color(16'h001F, 1'b0);
    send_color(16'h03E0, 1'b1);
    send_color(16'h7C00, 1'b0);
    drain();

    // tone saturation, zero tone and unit tone
    program_regs(MODE_TONE, 11'd2047, 11'd0, 11'd256, 15'h0, 8'd0, 8'd1, 1'b0);
    send_color(16'h7FFF, 1'b1);
    send_color(16'h4210, 1'b0);
    send_color(16'h8C63, 1'b0);
    drain();

    // fade overshoot, clamped at both rails
    program_regs(MODE_FADE, 11'd256, 11'd256, 11'd256, 15'h7FFF, 8'd255, 8'd1,
                 1'b0);
    send_color(16'h0000, 1'b0);
    send_color(16'h4210, 1'b1);
    drain();
    program_regs(MODE_FADE, 11'd256, 11'd256, 11'd256, 15'h03E0, 8'd255, 8'd1,
                 1'b0);
    send_color(16'h7C1F, 1'b0);
    drain();

    // zero duration leaves colors alone; stray write to an unknown index
    program_regs(MODE_FADE, 11'd256, 11'd256, 11'd256, 15'h5555, 8'd100, 8'd0,
                 1'b1);
    send_color(16'h1234, 1'b1);
    send_color(16'hFFFF, 1'b0);
    drain();

    // truncation toward zero in both directions
    program_regs(MODE_FADE, 11'd256, 11'd256, 11'd256, 15'h4210, 8'd3, 8'd7,
                 1'b0);
    send_color(16'h7C1F, 1'b0);
    send_color(16'h0000, 1'b1);
    drain();

    // unused mode passes the color with bit 15 cleared
    program_regs(MODE_RAW, 11'd0, 11'd2047, 11'd1, 15'h0, 8'd0, 8'd1, 1'b0);
    send_color(16'hABCD, 1'b1);
    send_color(16'h8000, 1'b0);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) mode = MODE_GRAY;
      else if (sel < 6) mode = MODE_TONE;
      else if (sel < 9) mode = MODE_FADE;
      else mode = MODE_RAW;
      sel = $urandom_range(0, 15);
      dur = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd1 : (sel == 2) ? 8'd255
          : 8'($urandom_range(1, 255));
      program_regs(mode, pick_tone(), pick_tone(), pick_tone(),
                   ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 15'h7FFF : 15'h0)
                                               : 15'($urandom_range(0, 32767)),
                   pick_byte(), dur, $urandom_range(0, 3) == 0);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 77; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 77; end
        default: begin idle_pct = 22; stall_pct <= 22; end
      endcase
      for (int i = 0; i < 150; i++) begin
        if (phase == 4 && i == 40)
          hold_id <= hold_id + 1;
        if (phase == 6 && i == 75) begin
          in_tvalid <= 1'b0;
          while (chk.pending() != 0) @(posedge clk);
        end
        send_color(pick_color(), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    stall_pct <= 0;
    repeat (20) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
